FILE: hdl/bmp_blit_pkg.sv
// Shared types and constants for the BMP pixel stream blit unit.
// No dependencies; compiled first.
package bmp_blit_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;

    localparam int IDX_W   = 19;
    localparam int COLOR_W = 32;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int SX_W = (SCREEN_WIDTH  > 1) ? $clog2(SCREEN_WIDTH)  : 1;
    localparam int SY_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    // 16-bit signed arithmetic is ample for the screen coordinates
    localparam int COORD_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ORIGIN_X     = 3'd0;
    localparam cfg_idx_t CFG_ORIGIN_Y     = 3'd1;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd2;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd3;
    localparam cfg_idx_t CFG_DEPTH_MODE   = 3'd4;

    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;
    localparam logic [1:0] PHASE_ALPHA = 2'd3;

    typedef struct packed {
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic [12:0]        image_width;
        logic signed [13:0] image_height;
        logic               depth_mode;
    } cfg_t;

    typedef struct packed {
        logic [SX_W-1:0]    sx;
        logic [SY_W-1:0]    sy;
        logic [COLOR_W-1:0] color;
    } hit_t;

endpackage

FILE: hdl/bmp_blit_byte_if.sv
// Byte input channel: valid/ready with one pixel array byte.
// Depends on bmp_blit_pkg.
interface bmp_blit_byte_if import bmp_blit_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

FILE: hdl/bmp_blit_pix_if.sv
// Framebuffer write channel: valid/ready with index and ARGB colour.
// Depends on bmp_blit_pkg.
interface bmp_blit_pix_if import bmp_blit_pkg::*;;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] argb_color;

    modport source (output valid, output pixel_index, output argb_color, input ready);
    modport sink   (input valid, input pixel_index, input argb_color, output ready);
endinterface

FILE: hdl/bmp_blit_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on bmp_blit_pkg.
interface bmp_blit_cfg_if import bmp_blit_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/bmp_pixel_stream_blit_unit.sv
// Top level of the BMP pixel stream blit unit.
// Depends on bmp_blit_pkg, the channel interfaces, bmp_blit_cfg,
// bmp_blit_decode and bmp_blit_addr.
//
// Usage:
//   cfg     : register writes (index, data); always ready. Write only while
//             the block is idle.
//   byte_in : BMP pixel array bytes and padding, one item per ready cycle.
//   pix_out : framebuffer writes (pixel_index, argb_color).
// Throughput is one byte per cycle while byte_in.ready is high. A byte
// that completes a visible pixel passes through the coordinate register,
// then the index multiply into the result register that drives pix_out.
// Clipped pixels and non-final bytes give nothing.
// When pix_out stalls, the coordinate register still takes one more pixel;
// byte_in.ready drops only when both stages are full.
// Reset clears the stream counters and sets the registers to origin 0,0,
// width 1, height 1, 24-bit mode. No clearing pass is needed.
module bmp_pixel_stream_blit_unit import bmp_blit_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bmp_blit_cfg_if.sink   cfg,
    bmp_blit_byte_if.sink  byte_in,
    bmp_blit_pix_if.source pix_out
);

    cfg_t cfg_q;
    logic take;
    logic hit_valid;
    hit_t hit;
    logic up_ready;

    assign byte_in.ready = up_ready;
    assign take          = byte_in.valid && up_ready;

    bmp_blit_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    bmp_blit_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_q),
        .take       (take),
        .pixel_byte (byte_in.pixel_byte),
        .hit_valid  (hit_valid),
        .hit        (hit)
    );

    bmp_blit_addr u_addr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit       (hit),
        .up_ready  (up_ready),
        .pix_out   (pix_out)
    );

endmodule

FILE: hdl/bmp_blit_decode.sv
// Byte assembly, row/column counters, padding skip and screen clipping.
// Depends on bmp_blit_pkg.
module bmp_blit_decode import bmp_blit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              take,
    input  logic [BYTE_W-1:0] pixel_byte,
    output logic              hit_valid,
    output hit_t              hit
);

    logic [1:0]  byte_phase_reg,   byte_phase_next;
    logic [7:0]  blue_held_reg,    blue_held_next;
    logic [7:0]  green_held_reg,   green_held_next;
    logic [7:0]  red_held_reg,     red_held_next;
    logic [12:0] column_count_reg, column_count_next;
    logic [12:0] row_count_reg,    row_count_next;
    logic [1:0]  padding_left_reg, padding_left_next;

    logic               finish;
    logic [7:0]         alpha;
    logic [7:0]         red;
    logic [13:0]        abs_h;
    logic               h_pos;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ox_ext;
    logic [COORD_W-1:0] oy_ext;
    logic [COORD_W-1:0] h_ext;
    logic [COORD_W-1:0] row_ext;
    logic               visible;
    logic [13:0]        col_inc;
    logic [13:0]        row_inc;

    assign abs_h   = cfg.image_height[13] ? 14'(-cfg.image_height) : cfg.image_height;
    assign h_pos   = !cfg.image_height[13] && (cfg.image_height != 14'sd0);
    assign ox_ext  = {{(COORD_W-13){cfg.origin_x[12]}}, cfg.origin_x};
    assign oy_ext  = {{(COORD_W-13){cfg.origin_y[12]}}, cfg.origin_y};
    assign h_ext   = {{(COORD_W-14){cfg.image_height[13]}}, cfg.image_height};
    assign row_ext = {{(COORD_W-13){1'b0}}, row_count_reg};

    assign sx = {{(COORD_W-13){1'b0}}, column_count_reg} + ox_ext;
    assign sy = h_pos ? (h_ext - COORD_W'(1) - row_ext + oy_ext) : (row_ext + oy_ext);

    assign visible = (cfg.image_width != 13'd0) && (abs_h != 14'd0)
                   && !sx[COORD_W-1] && (sx < COORD_W'(SCREEN_WIDTH))
                   && !sy[COORD_W-1] && (sy < COORD_W'(SCREEN_HEIGHT));

    assign col_inc = {1'b0, column_count_reg} + 14'd1;
    assign row_inc = {1'b0, row_count_reg} + 14'd1;

    assign red   = (byte_phase_reg == PHASE_RED) ? pixel_byte : red_held_reg;
    assign alpha = (byte_phase_reg == PHASE_ALPHA) ? pixel_byte : 8'd0;

    always_comb
    begin
        finish = 1'b0;
        if (padding_left_reg == 2'd0)
        begin
            case (byte_phase_reg)
                PHASE_RED:   finish = !cfg.depth_mode;
                PHASE_ALPHA: finish = 1'b1;
                default:     finish = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        byte_phase_next   = byte_phase_reg;
        blue_held_next    = blue_held_reg;
        green_held_next   = green_held_reg;
        red_held_next     = red_held_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        padding_left_next = padding_left_reg;
        if (take)
        begin
            if (padding_left_reg != 2'd0)
            begin
                padding_left_next = padding_left_reg - 2'd1;
            end
            else
            begin
                case (byte_phase_reg)
                    PHASE_BLUE:
                    begin
                        blue_held_next  = pixel_byte;
                        byte_phase_next = PHASE_GREEN;
                    end
                    PHASE_GREEN:
                    begin
                        green_held_next = pixel_byte;
                        byte_phase_next = PHASE_RED;
                    end
                    PHASE_RED:
                    begin
                        red_held_next   = pixel_byte;
                        byte_phase_next = cfg.depth_mode ? PHASE_ALPHA : PHASE_BLUE;
                    end
                    default:
                    begin
                        byte_phase_next = PHASE_BLUE;
                    end
                endcase
                if (finish)
                begin
                    if (col_inc >= {1'b0, cfg.image_width})
                    begin
                        column_count_next = 13'd0;
                        padding_left_next = cfg.depth_mode ? 2'd0 : cfg.image_width[1:0];
                        row_count_next    = (row_inc >= abs_h) ? 13'd0 : row_inc[12:0];
                    end
                    else
                    begin
                        column_count_next = col_inc[12:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_phase_reg   <= PHASE_BLUE;
            blue_held_reg    <= 8'd0;
            green_held_reg   <= 8'd0;
            red_held_reg     <= 8'd0;
            column_count_reg <= 13'd0;
            row_count_reg    <= 13'd0;
            padding_left_reg <= 2'd0;
        end
        else
        begin
            byte_phase_reg   <= byte_phase_next;
            blue_held_reg    <= blue_held_next;
            green_held_reg   <= green_held_next;
            red_held_reg     <= red_held_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            padding_left_reg <= padding_left_next;
        end
    end

    assign hit_valid = take && finish && visible;
    assign hit.sx    = sx[SX_W-1:0];
    assign hit.sy    = sy[SY_W-1:0];
    assign hit.color = {alpha, red, green_held_reg, blue_held_reg};

    // padding is only entered at a pixel boundary
    a_pad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        padding_left_reg != 2'd0 |-> byte_phase_reg == PHASE_BLUE)
        else $error("padding outside pixel boundary");

endmodule

FILE: hdl/bmp_blit_addr.sv
// Two-stage output pipe: coordinate register, then index multiply into the
// result register. Depends on bmp_blit_pkg and bmp_blit_pix_if.
module bmp_blit_addr import bmp_blit_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hit_valid,
    input  hit_t          hit,
    output logic          up_ready,
    bmp_blit_pix_if.source pix_out
);

    localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

    logic               a_valid_reg, a_valid_next;
    hit_t               a_reg;
    logic               b_valid_reg, b_valid_next;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [COLOR_W-1:0] b_color_reg;
    logic               b_load;
    logic [31:0]        row_base;
    logic [31:0]        idx_full;

    assign b_load   = a_valid_reg && (!b_valid_reg || pix_out.ready);
    assign up_ready = !a_valid_reg || b_load;

    assign row_base = 32'(a_reg.sy) * 32'(SCREEN_WIDTH);
    assign idx_full = 32'(a_reg.sx) + row_base;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (up_ready)
        begin
            a_valid_next = hit_valid;
        end
        b_valid_next = b_valid_reg;
        if (b_load)
        begin
            b_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && hit_valid)
        begin
            a_reg <= hit;
        end
        if (b_load)
        begin
            b_idx_reg   <= idx_full[IDX_W-1:0];
            b_color_reg <= a_reg.color;
        end
    end

    assign pix_out.valid       = b_valid_reg;
    assign pix_out.pixel_index = b_idx_reg;
    assign pix_out.argb_color  = b_color_reg;

    a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_load |=> a_valid_reg)
        else $error("stage A item dropped");

    a_fill_a: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && up_ready |=> a_valid_reg)
        else $error("accepted pixel not captured");

    a_move_b: assert property (@(posedge clk) disable iff (!rst_n)
        b_load |=> b_valid_reg)
        else $error("stage B load lost");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (SCREEN_PIXELS <= (1 << IDX_W)) |->
            32'(b_idx_reg) < 32'(SCREEN_PIXELS))
        else $error("pixel index beyond screen");

endmodule

FILE: hdl/bmp_blit_unit_top_placeholder_unused.sv
// Configuration register file for the blit unit.
// Depends on bmp_blit_pkg and bmp_blit_cfg_if.
module bmp_blit_cfg import bmp_blit_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bmp_blit_cfg_if.sink  cfg,
    output cfg_t          cfg_q
);

    cfg_t cfg_reg, cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ORIGIN_X:     cfg_next.origin_x     = cfg.data[12:0];
                CFG_ORIGIN_Y:     cfg_next.origin_y     = cfg.data[12:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg.data[12:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg.data;
                CFG_DEPTH_MODE:   cfg_next.depth_mode   = cfg.data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= 13'sd0;
            cfg_reg.origin_y     <= 13'sd0;
            cfg_reg.image_width  <= 13'd1;
            cfg_reg.image_height <= 14'sd1;
            cfg_reg.depth_mode   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_q = cfg_reg;

endmodule

FILE: dv/bmp_pixel_stream_blit_unit_test.sv
// Self-checking testbench for bmp_pixel_stream_blit_unit: streams pixel array bytes under
// a series of register settings, predicts every framebuffer write and checks them in order.
// Depends on bmp_blit_pkg, the three channel interfaces and the unit itself.
module bmp_pixel_stream_blit_unit_test;
    import bmp_blit_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam cfg_idx_t CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
    } fb_write_t;

    logic clk;
    logic rst_n;

    bmp_blit_cfg_if  cfg_ch ();
    bmp_blit_byte_if byte_ch ();
    bmp_blit_pix_if  pix_ch ();

    bmp_pixel_stream_blit_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .byte_in (byte_ch),
        .pix_out (pix_ch)
    );

    logic [BYTE_W-1:0] stream_bytes [$];
    fb_write_t         fb_writes_due [$];
    int                bytes_in_flight = 0;
    int                errors = 0;
    int unsigned       cycles = 0;
    int                send_idle_pct = 35;
    int                recv_stall_pct = 78;
    logic              byte_taken = 1'b0;
    logic              cfg_taken = 1'b0;

    // predicted registers and stream state
    logic signed [12:0] at_x = '0;
    logic signed [12:0] at_y = '0;
    logic [12:0]        img_w = 13'd1;
    logic signed [13:0] img_h = 14'sd1;
    logic               bgra_mode = 1'b0;
    logic [1:0]         phase = PHASE_BLUE;
    logic [7:0]         held_b = '0;
    logic [7:0]         held_g = '0;
    logic [7:0]         held_r = '0;
    logic [12:0]        col = '0;
    logic [12:0]        row = '0;
    logic [1:0]         pad = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Consumes one byte and queues the framebuffer write it completes, if visible.
    task automatic absorb_byte(input logic [7:0] b);
        logic [7:0] alpha;
        int         tall;
        int         sx;
        int         sy;
        fb_write_t  w;
        if (pad != 2'd0)
        begin
            pad = pad - 2'd1;
            return;
        end
        case (phase)
            PHASE_BLUE:
            begin
                held_b = b;
                phase = PHASE_GREEN;
                return;
            end
            PHASE_GREEN:
            begin
                held_g = b;
                phase = PHASE_RED;
                return;
            end
            PHASE_RED:
            begin
                held_r = b;
                if (bgra_mode)
                begin
                    phase = PHASE_ALPHA;
                    return;
                end
                alpha = 8'h00;
            end
            default:
                alpha = b;
        endcase
        phase = PHASE_BLUE;

        tall = (img_h < 0) ? -int'(img_h) : int'(img_h);
        sx = int'(col) + int'(at_x);
        if (img_h > 0)
            sy = int'(img_h) - 1 - int'(row) + int'(at_y);
        else
            sy = int'(row) + int'(at_y);

        if (img_w != 13'd0 && tall != 0 && sx >= 0 && sx < SCREEN_WIDTH
            && sy >= 0 && sy < SCREEN_HEIGHT)
        begin
            w.index = IDX_W'(sx + sy * SCREEN_WIDTH);
            w.color = {alpha, held_r, held_g, held_b};
            fb_writes_due.push_back(w);
        end

        if (int'(col) + 1 >= int'(img_w))
        begin
            col = '0;
            pad = bgra_mode ? 2'd0 : img_w[1:0];
            if (int'(row) + 1 >= tall)
                row = '0;
            else
                row = row + 13'd1;
        end
        else
            col = col + 13'd1;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n && (!byte_ch.valid || byte_taken))
        begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_ch.valid      <= 1'b1;
                byte_ch.pixel_byte <= stream_bytes.pop_front();
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        pix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor
    always @(posedge clk)
    begin
        fb_write_t due;
        byte_taken = 1'b0;
        cfg_taken  = 1'b0;
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (fb_writes_due.size() == 0)
                    report_mismatch($sformatf("unexpected write: index %0d colour %h",
                                              pix_ch.pixel_index, pix_ch.argb_color));
                else
                begin
                    due = fb_writes_due.pop_front();
                    if (pix_ch.pixel_index !== due.index)
                        report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                                  pix_ch.pixel_index, due.index));
                    if (pix_ch.argb_color !== due.color)
                        report_mismatch($sformatf("argb_color %h, expected %h",
                                                  pix_ch.argb_color, due.color));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_ORIGIN_X:     at_x = cfg_ch.data[12:0];
                    CFG_ORIGIN_Y:     at_y = cfg_ch.data[12:0];
                    CFG_IMAGE_WIDTH:  img_w = cfg_ch.data[12:0];
                    CFG_IMAGE_HEIGHT: img_h = cfg_ch.data[13:0];
                    CFG_DEPTH_MODE:   bgra_mode = cfg_ch.data[0];
                    default: ;
                endcase
                cfg_taken = 1'b1;
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                absorb_byte(byte_ch.pixel_byte);
                bytes_in_flight--;
                byte_taken = 1'b1;
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_in_flight++;
    endtask

    // waits until every byte is taken and every write has come, then lets the pipe drain
    task automatic settle();
        do
            @(negedge clk);
        while (bytes_in_flight != 0 || fb_writes_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int random_sent;
        int w;
        int h;
        int ox;
        int oy;
        int dm;
        int r;
        int n;
        int row_bytes;

        rst_n              = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_ORIGIN_X;
        cfg_ch.data        = '0;
        byte_ch.valid      = 1'b0;
        byte_ch.pixel_byte = '0;
        pix_ch.ready       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 24-bit image at the origin, one padding byte per row
        feed_byte(8'h00); feed_byte(8'hFF); feed_byte(8'h5A); feed_byte(8'h11);
        feed_byte(8'hA5); feed_byte(8'hC3); feed_byte(8'h3C); feed_byte(8'h7E);
        settle();

        // 32-bit top-down image at the bottom-right corner, stopped before alpha
        write_reg(CFG_DEPTH_MODE, 14'd1);
        write_reg(CFG_IMAGE_WIDTH, 14'd2);
        write_reg(CFG_IMAGE_HEIGHT, 14'(-2));
        write_reg(CFG_ORIGIN_X, 14'd798);
        write_reg(CFG_ORIGIN_Y, 14'd478);
        feed_byte(8'hFF); feed_byte(8'h00); feed_byte(8'h80);
        settle();

        // back to 24-bit: the pending byte still lands as alpha
        write_reg(CFG_DEPTH_MODE, 14'd0);
        feed_byte(8'hC3);
        settle();

        // zero width, far-off origin
        write_reg(CFG_ORIGIN_X, 14'(4095));
        write_reg(CFG_ORIGIN_Y, 14'(-4096));
        write_reg(CFG_IMAGE_WIDTH, 14'd0);
        write_reg(CFG_IMAGE_HEIGHT, 14'(-4096));
        feed_byte(8'h01); feed_byte(8'h02); feed_byte(8'h04);
        feed_byte(8'h08); feed_byte(8'h10); feed_byte(8'h20);
        settle();

        write_reg(CFG_IMAGE_WIDTH, 14'd4096);
        write_reg(CFG_IMAGE_HEIGHT, 14'd4096);
        write_reg(CFG_ORIGIN_X, 14'(-4096));
        write_reg(CFG_ORIGIN_Y, 14'(4095));
        write_reg(CFG_DEPTH_MODE, 14'd1);
        write_reg(CFG_SPARE, 14'h3FFF);
        feed_byte(8'h40); feed_byte(8'h80); feed_byte(8'hFF); feed_byte(8'h00);
        settle();

        // zero height
        write_reg(CFG_IMAGE_HEIGHT, 14'd0);
        write_reg(CFG_IMAGE_WIDTH, 14'd3);
        write_reg(CFG_DEPTH_MODE, 14'd0);
        write_reg(CFG_ORIGIN_X, 14'd0);
        write_reg(CFG_ORIGIN_Y, 14'd0);
        feed_byte(8'h12); feed_byte(8'h34); feed_byte(8'h56);

        w  = 3;
        h  = 0;
        dm = 0;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            settle();
            if (random_sent < RANDOM_BYTES / 3)
            begin
                send_idle_pct  = 35;
                recv_stall_pct = 78;
            end
            else if (random_sent < 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct  = 78;
                recv_stall_pct = 35;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            if ($urandom_range(9) < 7)
            begin
                r = $urandom_range(99);
                if (r < 80)      w = $urandom_range(9, 1);
                else if (r < 88) w = $urandom_range(900, 10);
                else if (r < 93) w = 4096;
                else if (r < 96) w = 0;
                else             w = $urandom_range(4096);
                write_reg(CFG_IMAGE_WIDTH, 14'(w));
            end
            if ($urandom_range(9) < 7)
            begin
                r = $urandom_range(99);
                if (r < 80)      h = $urandom_range(6, 1);
                else if (r < 88) h = $urandom_range(600, 7);
                else if (r < 93) h = 4096;
                else if (r < 96) h = 0;
                else             h = $urandom_range(4096);
                if ($urandom_range(1) != 0)
                    h = -h;
                write_reg(CFG_IMAGE_HEIGHT, 14'(h));
            end
            if ($urandom_range(9) < 7)
            begin
                r = $urandom_range(99);
                if (r < 75)      ox = int'($urandom_range(820)) - 10;
                else if (r < 90) ox = int'($urandom_range(8191)) - 4096;
                else             ox = ($urandom_range(1) != 0) ? 4095 : -4096;
                write_reg(CFG_ORIGIN_X, 14'(ox));
            end
            if ($urandom_range(9) < 7)
            begin
                r = $urandom_range(99);
                if (r < 75)      oy = int'($urandom_range(500)) - 10;
                else if (r < 90) oy = int'($urandom_range(8191)) - 4096;
                else             oy = ($urandom_range(1) != 0) ? 4095 : -4096;
                write_reg(CFG_ORIGIN_Y, 14'(oy));
            end
            if ($urandom_range(9) < 5)
            begin
                dm = $urandom_range(1);
                write_reg(CFG_DEPTH_MODE, 14'(dm));
            end

            // mostly whole images; the rest cut short or run over
            row_bytes = (dm != 0) ? 4 * w : 3 * w + (w % 4);
            n = row_bytes * ((h < 0) ? -h : h);
            if (n == 0 || n > 160)
                n = $urandom_range(160, 4);
            if ($urandom_range(9) == 0)
                n += $urandom_range(5, 1);
            repeat (n) feed_byte(8'($urandom()));
            random_sent += n;
        end

        settle();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bmp_blit_pkg.sv
hdl/bmp_blit_byte_if.sv
hdl/bmp_blit_pix_if.sv
hdl/bmp_blit_cfg_if.sv
hdl/bmp_blit_decode.sv
hdl/bmp_blit_addr.sv
hdl/bmp_blit_unit_top_placeholder_unused.sv
hdl/bmp_pixel_stream_blit_unit.sv
dv/bmp_pixel_stream_blit_unit_test.sv
